### hdl/smdh_pkg.sv
package smdh_pkg;

  localparam int RING_DEPTH_DEF = 512;
  localparam int COUNT_BITS_DEF = 32;
  localparam int BIN_COUNT      = 256;
  localparam int BIN_BITS       = $clog2(BIN_COUNT);
  localparam int COL_BITS       = 12;
  localparam int ROW_W_BITS     = 13;
  localparam int DISP_BITS      = 9;
  localparam int OUT_CNT_BITS   = 32;
  localparam int Q_DEPTH        = 4;
  localparam int Q_ADDR_BITS    = $clog2(Q_DEPTH);

  localparam logic [ROW_W_BITS-1:0] ROW_WIDTH_RST = 13'd1226;

  // input function codes
  localparam logic [1:0] FUNC_PIXEL = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_INC   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } hist_kind_t;

  typedef struct packed {
    hist_kind_t          kind;
    logic [BIN_BITS-1:0] bin;
  } hist_op_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] disparity_raw;
    logic [7:0]  left_pixel;
    logic [7:0]  right_pixel;
    logic [7:0]  bin_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  bin_echo;
    logic [31:0] bin_count;
  } out_item_t;

endpackage

### hdl/smdh_front.sv
module smdh_front import smdh_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [ROW_W_BITS-1:0] row_width,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  push_valid,
  input  logic                  push_ready,
  output hist_op_t              push_op
);

  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam int SUM_W   = RING_AW + 1;
  localparam logic [SUM_W-1:0]   DEPTH_W   = SUM_W'(RING_DEPTH);
  localparam logic [RING_AW-1:0] PTR_LAST  = RING_AW'(RING_DEPTH - 1);

  logic [7:0] ring [RING_DEPTH];
  logic [7:0] ring_q_r;

  logic [COL_BITS-1:0] col_r, col_nxt;
  logic [RING_AW-1:0]  ptr_r, ptr_nxt;
  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_push_r;
  hist_kind_t          s1_kind_r;
  logic                s1_d0_r;
  logic [7:0]          s1_left_r, s1_right_r, s1_bin_r;

  logic                  accept, pix_acc, s1_done;
  logic [DISP_BITS:0]    d_sum;
  logic [DISP_BITS-1:0]  d;
  logic                  hit;
  logic [ROW_W_BITS-1:0] col_inc;
  logic                  col_wrap;
  logic [SUM_W-1:0]      rd_sum;
  logic [RING_AW-1:0]    rd_addr;
  logic [7:0]            matched, diff;

  assign push_valid = s1_valid_r && s1_push_r;
  assign s1_done    = !push_valid || push_ready;
  assign in_ready   = !s1_valid_r || s1_done;
  assign accept     = in_valid && in_ready;
  assign pix_acc    = accept && (in_item.func == FUNC_PIXEL);

  // round disparity to whole pixels
  assign d_sum = {1'b0, in_item.disparity_raw[15:7]} + (DISP_BITS+1)'(1);
  assign d     = d_sum[DISP_BITS:1];
  assign hit   = (in_item.disparity_raw != 16'd0) &&
                 ({{(COL_BITS-DISP_BITS){1'b0}}, d} <= col_r);

  // ring slot of column minus disparity
  always_comb begin
    if ({1'b0, ptr_r} >= SUM_W'(d)) begin
      rd_sum = {1'b0, ptr_r} - SUM_W'(d);
    end else begin
      rd_sum = {1'b0, ptr_r} + DEPTH_W - SUM_W'(d);
    end
    rd_addr = rd_sum[RING_AW-1:0];
  end

  assign col_inc  = {1'b0, col_r} + ROW_W_BITS'(1);
  assign col_wrap = (col_inc >= row_width) || (col_r == {COL_BITS{1'b1}});

  always_comb begin
    col_nxt = col_r;
    ptr_nxt = ptr_r;
    if (pix_acc) begin
      if (col_wrap) begin
        col_nxt = '0;
        ptr_nxt = '0;
      end else begin
        col_nxt = col_inc[COL_BITS-1:0];
        ptr_nxt = (ptr_r == PTR_LAST) ? '0 : ptr_r + RING_AW'(1);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_done) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      ptr_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      ptr_r      <= ptr_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // ring: write current byte, read the match slot
  always_ff @(posedge clk) begin
    if (pix_acc) begin
      ring[ptr_r] <= in_item.right_pixel;
      ring_q_r    <= ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_left_r  <= in_item.left_pixel;
      s1_right_r <= in_item.right_pixel;
      s1_bin_r   <= in_item.bin_index;
      s1_d0_r    <= (d == '0);
      case (in_item.func)
        FUNC_PIXEL: begin
          s1_kind_r <= OP_INC;
          s1_push_r <= hit;
        end
        FUNC_READ: begin
          s1_kind_r <= OP_READ;
          s1_push_r <= 1'b1;
        end
        FUNC_CLEAR: begin
          s1_kind_r <= OP_CLEAR;
          s1_push_r <= 1'b1;
        end
        default: begin
          s1_kind_r <= OP_READ;
          s1_push_r <= 1'b0;
        end
      endcase
    end
  end

  // zero disparity matches the byte just written
  assign matched = s1_d0_r ? s1_right_r : ring_q_r;
  assign diff    = (s1_left_r >= matched) ? (s1_left_r - matched) : (matched - s1_left_r);

  assign push_op.kind = s1_kind_r;
  assign push_op.bin  = (s1_kind_r == OP_INC) ? diff : s1_bin_r;

endmodule

### hdl/smdh_queue.sv
module smdh_queue import smdh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  hist_op_t push_op,
  output logic     pop_valid,
  input  logic     pop_ready,
  output hist_op_t pop_op
);

  hist_op_t               slots [Q_DEPTH];
  logic [Q_ADDR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_ADDR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_ADDR_BITS:0]   cnt_r, cnt_nxt;
  logic                   do_push, do_pop;

  assign push_ready = (cnt_r != (Q_ADDR_BITS+1)'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_op     = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_ADDR_BITS'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + Q_ADDR_BITS'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (Q_ADDR_BITS+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (Q_ADDR_BITS+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= push_op;
    end
  end

endmodule

### hdl/smdh_back.sv
module smdh_back import smdh_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  hist_op_t  pop_op,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic [COUNT_BITS-1:0] hist [BIN_COUNT];
  logic [BIN_COUNT-1:0]  vld_r, vld_nxt;

  logic                  b2_valid_r, b2_valid_nxt;
  hist_op_t              b2_op_r;
  logic [COUNT_BITS-1:0] mem_q_r;
  logic                  vld_q_r;
  logic                  fwd_hit_r;
  logic [COUNT_BITS-1:0] fwd_val_r;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r;

  logic                    do_pop, b2_go, b2_wr, b2_rd;
  logic [COUNT_BITS-1:0]   cur, new_val;
  logic [OUT_CNT_BITS-1:0] cur_sat;

  assign b2_rd     = b2_valid_r && (b2_op_r.kind == OP_READ);
  assign b2_go     = !b2_rd || !out_valid_r || out_ready;
  assign b2_wr     = b2_valid_r && (b2_op_r.kind != OP_READ);
  assign pop_ready = !b2_valid_r || b2_go;
  assign do_pop    = pop_valid && pop_ready;

  // bypass the write made at the edge this bin was read
  assign cur = fwd_hit_r ? fwd_val_r : (vld_q_r ? mem_q_r : '0);

  always_comb begin
    case (b2_op_r.kind)
      OP_INC:   new_val = (cur == {COUNT_BITS{1'b1}}) ? cur : cur + COUNT_BITS'(1);
      OP_CLEAR: new_val = '0;
      default:  new_val = cur;
    endcase
  end

  generate
    if (COUNT_BITS > OUT_CNT_BITS) begin : g_sat_wide
      assign cur_sat = (|cur[COUNT_BITS-1:OUT_CNT_BITS]) ? {OUT_CNT_BITS{1'b1}}
                                                        : cur[OUT_CNT_BITS-1:0];
    end else if (COUNT_BITS == OUT_CNT_BITS) begin : g_sat_same
      assign cur_sat = cur;
    end else begin : g_sat_narrow
      assign cur_sat = {{(OUT_CNT_BITS-COUNT_BITS){1'b0}}, cur};
    end
  endgenerate

  always_comb begin
    b2_valid_nxt = b2_valid_r;
    if (do_pop) begin
      b2_valid_nxt = 1'b1;
    end else if (b2_go) begin
      b2_valid_nxt = 1'b0;
    end
    vld_nxt = vld_r;
    if (b2_wr) begin
      vld_nxt[b2_op_r.bin] = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (b2_rd && b2_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_valid_r  <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      b2_valid_r  <= b2_valid_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // histogram memory, one read and one write port
  always_ff @(posedge clk) begin
    if (b2_wr) begin
      hist[b2_op_r.bin] <= new_val;
    end
    if (do_pop) begin
      mem_q_r <= hist[pop_op.bin];
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      b2_op_r   <= pop_op;
      vld_q_r   <= vld_r[pop_op.bin];
      fwd_hit_r <= b2_wr && (b2_op_r.bin == pop_op.bin);
      fwd_val_r <= new_val;
    end
    if (b2_rd && b2_go) begin
      out_item_r.bin_echo  <= b2_op_r.bin;
      out_item_r.bin_count <= cur_sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### hdl/stereo_match_difference_histogram.sv
// stereo match difference histogram: takes one transaction per clock unless read results
// back up. pixel transactions (raster order) write the right byte into a row ring and,
// when the ground-truth disparity is nonzero and, rounded, fits within the current
// column, bump the histogram bin of |left - matched right|; read transactions return
// one bin (saturated to 32 bits), clear transactions zero one bin. a read result passes
// the front stage, the queue and the back stage to the result register, where it waits
// while out_ready is low; the histogram read-modify-write (one read and one write port)
// sets the rate, retiring one update per cycle with a one-deep write bypass unless a
// result waits. the bins come up zero right after reset through per-bin valid flags, so
// there is no clearing pass. row_width may only be rewritten while the block is idle.
module stereo_match_difference_histogram import smdh_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [ROW_W_BITS-1:0] cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item
);

  logic [ROW_W_BITS-1:0] row_width_r, row_width_nxt;

  // front to queue
  logic     push_valid, push_ready;
  hist_op_t push_op;
  // queue to back
  logic     pop_valid, pop_ready;
  hist_op_t pop_op;

  // row width register
  assign row_width_nxt = cfg_wr_en ? cfg_wr_data : row_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RST;
    end else begin
      row_width_r <= row_width_nxt;
    end
  end

  // front: column tracking, right-row ring, difference and bin selection
  smdh_front #(
    .RING_DEPTH (RING_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .row_width  (row_width_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  // short queue so the front keeps taking pixels while a read result waits
  smdh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  // back: histogram read-modify-write and result register
  smdh_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_op    (pop_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
